[hdl/rgbcc_pkg.sv]
// rgbcc_pkg: shared types, widths and constants of the RGB565 color classifier
package rgbcc_pkg;

    // field and datapath widths
    localparam int PIX_W      = 16;
    localparam int COMP_W     = 8;
    localparam int VAL_W      = 8;
    localparam int SUM_W      = COMP_W + 1;
    localparam int DIFF_W     = COMP_W + 1;
    localparam int NUM_W      = 16;
    localparam int DEN_W      = SUM_W;
    localparam int DIV_STAGES = NUM_W;
    // signed hue sum: quotient plus sector base with room for the sign
    localparam int HUE_SUM_W  = NUM_W + 2;

    // configuration port
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = ADDR_W - 2;

    // scale constants
    localparam int HUE_SECTOR      = 40;
    localparam int HUE_BASE_GREEN  = 80;
    localparam int HUE_BASE_BLUE   = 160;
    localparam int SCALE_MAX       = 240;
    localparam int DEN_FLIP        = 511;
    // lightness <= 120 exactly when max+min <= 257
    localparam int LIGHT_SPLIT_SUM = 257;
    // lightness == 0 exactly when max+min <= 2
    localparam int LIGHT_ZERO_SUM  = 2;
    // lightness = (sum * 61681) >> 17, exact for every 9-bit sum
    localparam int LIGHT_RECIP     = 61681;
    localparam int LIGHT_SHIFT     = 17;
    localparam int PROD_W          = LIGHT_SHIFT + VAL_W;

    // register reset values
    localparam logic [VAL_W-1:0] RST_HUE_LOW    = VAL_W'(60);
    localparam logic [VAL_W-1:0] RST_HUE_HIGH   = VAL_W'(110);
    localparam logic [VAL_W-1:0] RST_SAT_LOW    = VAL_W'(45);
    localparam logic [VAL_W-1:0] RST_SAT_HIGH   = VAL_W'(110);
    localparam logic [VAL_W-1:0] RST_LIGHT_LOW  = VAL_W'(90);
    localparam logic [VAL_W-1:0] RST_LIGHT_HIGH = VAL_W'(210);

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_HUE_LOW    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_HUE_HIGH   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SAT_LOW    = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SAT_HIGH   = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_LOW  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_HIGH = REG_IDX_W'(5);

    // which component holds the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [VAL_W-1:0] hue_low;
        logic [VAL_W-1:0] hue_high;
        logic [VAL_W-1:0] sat_low;
        logic [VAL_W-1:0] sat_high;
        logic [VAL_W-1:0] light_low;
        logic [VAL_W-1:0] light_high;
    } cfg_t;

    // per-pixel info that travels beside the dividers
    typedef struct packed {
        sector_t          sector;
        logic             hue_neg;
        logic             grey;
        logic             sat_zero;
        logic [VAL_W-1:0] lightness;
    } side_t;

    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [NUM_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
        logic [NUM_W-1:0] sat_num;
        logic [DEN_W-1:0] sat_den;
    } front_t;

endpackage

[hdl/rgb565_hls_color_classifier.sv]
// rgb565_hls_color_classifier: top level of the RGB565 hue/saturation/lightness classifier
//
//   channel   handshake                 payload
//   -------   -----------------------   ----------------------------------------
//   input     start, busy               pixel
//   result    done (one-cycle strobe)   hue, saturation, lightness, matched
//   config    APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One pixel per clock. A pixel passes two front stages, sixteen divider stages
// (one quotient bit each, two dividers side by side) and two back stages. busy
// stays low and the pipeline never stalls, so the receiver must take every
// result on its strobe; the block does not enforce this. Reset clears the valid
// bits and loads the bound registers with their defaults; no clearing pass.
module rgb565_hls_color_classifier (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rgbcc_pkg::PIX_W-1:0]   pixel,
    output logic                          done,
    output logic [rgbcc_pkg::VAL_W-1:0]   hue,
    output logic [rgbcc_pkg::VAL_W-1:0]   saturation,
    output logic [rgbcc_pkg::VAL_W-1:0]   lightness,
    output logic                          matched,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [rgbcc_pkg::DATA_W-1:0]  pwdata,
    output logic [rgbcc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import rgbcc_pkg::*;

    cfg_t                  cfg;
    front_t                front;
    logic [NUM_W-1:0]      hue_q;
    logic [NUM_W-1:0]      sat_q;
    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] valid_next;
    side_t                 side_reg [DIV_STAGES];

    assign busy = 1'b0;

    rgbcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgbcc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .pixel (pixel),
        .front (front)
    );

    rgbcc_div u_hue_div (
        .clk      (clk),
        .dividend (front.hue_num),
        .divisor  (front.hue_den),
        .quotient (hue_q)
    );

    rgbcc_div u_sat_div (
        .clk      (clk),
        .dividend (front.sat_num),
        .divisor  (front.sat_den),
        .quotient (sat_q)
    );

    // valid bits and side info follow the divider stages
    assign valid_next = {valid_reg[DIV_STAGES-2:0], front.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= front.side;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    rgbcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (valid_reg[DIV_STAGES-1]),
        .side       (side_reg[DIV_STAGES-1]),
        .hue_q      (hue_q),
        .sat_q      (sat_q),
        .cfg        (cfg),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .matched    (matched)
    );

endmodule

[hdl/rgbcc_regs.sv]
// rgbcc_regs: APB register file holding the six classification bounds
module rgbcc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [rgbcc_pkg::DATA_W-1:0]  pwdata,
    output logic [rgbcc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output rgbcc_pkg::cfg_t               cfg
);
    import rgbcc_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_HUE_LOW:    cfg_next.hue_low    = pwdata[VAL_W-1:0];
                REG_HUE_HIGH:   cfg_next.hue_high   = pwdata[VAL_W-1:0];
                REG_SAT_LOW:    cfg_next.sat_low    = pwdata[VAL_W-1:0];
                REG_SAT_HIGH:   cfg_next.sat_high   = pwdata[VAL_W-1:0];
                REG_LIGHT_LOW:  cfg_next.light_low  = pwdata[VAL_W-1:0];
                REG_LIGHT_HIGH: cfg_next.light_high = pwdata[VAL_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low    <= RST_HUE_LOW;
            cfg_reg.hue_high   <= RST_HUE_HIGH;
            cfg_reg.sat_low    <= RST_SAT_LOW;
            cfg_reg.sat_high   <= RST_SAT_HIGH;
            cfg_reg.light_low  <= RST_LIGHT_LOW;
            cfg_reg.light_high <= RST_LIGHT_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_HUE_LOW:    prdata = DATA_W'(cfg_reg.hue_low);
            REG_HUE_HIGH:   prdata = DATA_W'(cfg_reg.hue_high);
            REG_SAT_LOW:    prdata = DATA_W'(cfg_reg.sat_low);
            REG_SAT_HIGH:   prdata = DATA_W'(cfg_reg.sat_high);
            REG_LIGHT_LOW:  prdata = DATA_W'(cfg_reg.light_low);
            REG_LIGHT_HIGH: prdata = DATA_W'(cfg_reg.light_high);
            default:        prdata = '0;
        endcase
    end

endmodule

[hdl/rgbcc_front.sv]
// rgbcc_front: pixel expansion, max/min, divider operands and lightness (two stages)
module rgbcc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rgbcc_pkg::PIX_W-1:0]  pixel,
    output rgbcc_pkg::front_t            front
);
    import rgbcc_pkg::*;

    logic [COMP_W-1:0]        r;
    logic [COMP_W-1:0]        g;
    logic [COMP_W-1:0]        b;
    logic [COMP_W-1:0]        mx;
    logic [COMP_W-1:0]        mn;
    sector_t                  sec;
    logic signed [DIFF_W-1:0] diff;

    logic                     a_valid_reg;
    sector_t                  a_sector_reg;
    logic signed [DIFF_W-1:0] a_diff_reg;
    logic [COMP_W-1:0]        a_dif_reg;
    logic [SUM_W-1:0]         a_sum_reg;

    logic [DIFF_W-1:0]        neg_diff;
    logic [COMP_W-1:0]        mag;
    logic [PROD_W-1:0]        light_prod;
    front_t                   front_reg;
    front_t                   front_next;

    // stage a: expand to 8 bits, find max, min and the winning component
    always_comb
    begin
        r  = {pixel[15:11], 3'b000};
        g  = {pixel[10:5], 2'b00};
        b  = {pixel[4:0], 3'b000};
        mx = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        if (mx == r)
        begin
            sec  = SEC_RED;
            diff = $signed({1'b0, g}) - $signed({1'b0, b});
        end
        else if (mx == g)
        begin
            sec  = SEC_GREEN;
            diff = $signed({1'b0, b}) - $signed({1'b0, r});
        end
        else
        begin
            sec  = SEC_BLUE;
            diff = $signed({1'b0, r}) - $signed({1'b0, g});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sector_reg <= sec;
        a_diff_reg   <= diff;
        a_dif_reg    <= mx - mn;
        a_sum_reg    <= SUM_W'(mx) + SUM_W'(mn);
    end

    // stage b: scaled numerators, divisors and lightness by reciprocal
    assign neg_diff   = DIFF_W'(-a_diff_reg);
    assign mag        = a_diff_reg[DIFF_W-1] ? neg_diff[COMP_W-1:0] : a_diff_reg[COMP_W-1:0];
    assign light_prod = PROD_W'(a_sum_reg) * PROD_W'(LIGHT_RECIP);

    always_comb
    begin
        front_next.valid          = a_valid_reg;
        front_next.side.sector    = a_sector_reg;
        front_next.side.hue_neg   = a_diff_reg[DIFF_W-1];
        front_next.side.grey      = (a_dif_reg == '0);
        front_next.side.sat_zero  = (a_sum_reg <= SUM_W'(LIGHT_ZERO_SUM));
        front_next.side.lightness = light_prod[PROD_W-1:LIGHT_SHIFT];
        front_next.hue_num        = NUM_W'(mag) * NUM_W'(HUE_SECTOR);
        front_next.sat_num        = NUM_W'(a_dif_reg) * NUM_W'(SCALE_MAX);
        if (a_dif_reg == '0)
        begin
            front_next.hue_den = DEN_W'(1);
        end
        else
        begin
            front_next.hue_den = DEN_W'(a_dif_reg);
        end
        if (a_sum_reg == '0)
        begin
            front_next.sat_den = DEN_W'(1);
        end
        else if (a_sum_reg <= SUM_W'(LIGHT_SPLIT_SUM))
        begin
            front_next.sat_den = a_sum_reg;
        end
        else
        begin
            front_next.sat_den = DEN_W'(DEN_FLIP) - a_sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

[hdl/rgbcc_div.sv]
// rgbcc_div: pipelined restoring divider, one quotient bit per stage
module rgbcc_div (
    input  logic                         clk,
    input  logic [rgbcc_pkg::NUM_W-1:0]  dividend,
    input  logic [rgbcc_pkg::DEN_W-1:0]  divisor,
    output logic [rgbcc_pkg::NUM_W-1:0]  quotient
);
    import rgbcc_pkg::*;

    logic [DEN_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] rem_next [DIV_STAGES];
    logic [NUM_W-1:0] dq_reg   [DIV_STAGES];
    logic [NUM_W-1:0] dq_next  [DIV_STAGES];
    logic [DEN_W-1:0] dv_reg   [DIV_STAGES];
    logic [DEN_W-1:0] dv_next  [DIV_STAGES];

    // each stage shifts in one dividend bit and tries one subtract
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] dq_in;
        logic [DEN_W-1:0] dv_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   trial_sub;
        logic             fits;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign dq_in  = dividend;
            assign dv_in  = divisor;
        end
        else
        begin : g_chain
            assign rem_in = rem_reg[s-1];
            assign dq_in  = dq_reg[s-1];
            assign dv_in  = dv_reg[s-1];
        end

        assign trial       = {rem_in, dq_in[NUM_W-1]};
        assign fits        = (trial >= {1'b0, dv_in});
        assign trial_sub   = trial - {1'b0, dv_in};
        assign rem_next[s] = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        assign dq_next[s]  = {dq_in[NUM_W-2:0], fits};
        assign dv_next[s]  = dv_in;

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next[s];
            dq_reg[s]  <= dq_next[s];
            dv_reg[s]  <= dv_next[s];
        end
    end

    assign quotient = dq_reg[DIV_STAGES-1];

endmodule

[hdl/rgbcc_back.sv]
// rgbcc_back: hue/saturation assembly with clamping, then the bound check (two stages)
module rgbcc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid,
    input  rgbcc_pkg::side_t             side,
    input  logic [rgbcc_pkg::NUM_W-1:0]  hue_q,
    input  logic [rgbcc_pkg::NUM_W-1:0]  sat_q,
    input  rgbcc_pkg::cfg_t              cfg,
    output logic                         done,
    output logic [rgbcc_pkg::VAL_W-1:0]  hue,
    output logic [rgbcc_pkg::VAL_W-1:0]  saturation,
    output logic [rgbcc_pkg::VAL_W-1:0]  lightness,
    output logic                         matched
);
    import rgbcc_pkg::*;

    logic signed [HUE_SUM_W-1:0] hq;
    logic signed [HUE_SUM_W-1:0] hbase;
    logic signed [HUE_SUM_W-1:0] hsum;
    logic [VAL_W-1:0]            hue_next;
    logic [VAL_W-1:0]            sat_next;
    logic                        match_next;

    logic                        d_valid_reg;
    logic [VAL_W-1:0]            d_hue_reg;
    logic [VAL_W-1:0]            d_sat_reg;
    logic [VAL_W-1:0]            d_light_reg;

    logic                        done_reg;
    logic [VAL_W-1:0]            hue_reg;
    logic [VAL_W-1:0]            sat_reg;
    logic [VAL_W-1:0]            light_reg;
    logic                        matched_reg;

    // signed quotient plus sector base, then clamp
    always_comb
    begin
        if (side.hue_neg)
        begin
            hq = -$signed({2'b00, hue_q});
        end
        else
        begin
            hq = $signed({2'b00, hue_q});
        end
        case (side.sector)
            SEC_RED:   hbase = side.hue_neg ? HUE_SUM_W'(SCALE_MAX) : '0;
            SEC_GREEN: hbase = HUE_SUM_W'(HUE_BASE_GREEN);
            SEC_BLUE:  hbase = HUE_SUM_W'(HUE_BASE_BLUE);
            default:   hbase = '0;
        endcase
        hsum = hbase + hq;
        if (side.grey || (hsum < 0))
        begin
            hue_next = '0;
        end
        else if (hsum > $signed(HUE_SUM_W'(SCALE_MAX)))
        begin
            hue_next = VAL_W'(SCALE_MAX);
        end
        else
        begin
            hue_next = hsum[VAL_W-1:0];
        end
        if (side.grey || side.sat_zero)
        begin
            sat_next = '0;
        end
        else if (sat_q > NUM_W'(SCALE_MAX))
        begin
            sat_next = VAL_W'(SCALE_MAX);
        end
        else
        begin
            sat_next = sat_q[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_hue_reg   <= hue_next;
        d_sat_reg   <= sat_next;
        d_light_reg <= side.lightness;
    end

    // strict window check on all three values
    assign match_next = (d_hue_reg > cfg.hue_low) && (d_hue_reg < cfg.hue_high) &&
                        (d_sat_reg > cfg.sat_low) && (d_sat_reg < cfg.sat_high) &&
                        (d_light_reg > cfg.light_low) && (d_light_reg < cfg.light_high);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg     <= d_hue_reg;
        sat_reg     <= d_sat_reg;
        light_reg   <= d_light_reg;
        matched_reg <= match_next;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg;
    assign matched    = matched_reg;

endmodule
